/* rtl/core/can_std_id_filter_rx_fifo_defines.svh */
// ----------------------------------------------------------------------------
// CAN receive filter / FIFO assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CAN_STD_ID_FILTER_RX_FIFO_DEFINES_SVH
`define CAN_STD_ID_FILTER_RX_FIFO_DEFINES_SVH

// condition holds at every edge out of reset
`define CANFRX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define CANFRX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define CANFRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/canfrx_pkg.sv */
// ----------------------------------------------------------------------------
// canfrx_pkg
// Types and constants of the CAN standard-id filter and receive FIFO.
// ----------------------------------------------------------------------------
package canfrx_pkg;

  // default sizes
  localparam int FILTERS_DEF  = 8;
  localparam int RX_DEPTH_DEF = 8;

  // field widths
  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int CNT_OUT_W = 4;
  localparam int CFG_IDX_W = 1;

  // item operations
  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_POP   = 2'd1,
    OP_ADD   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERWRITE     = 1'd0,
    REG_REJECT_REMOTE = 1'd1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_HEAD_RD,
    S_HEAD
  } state_t;

endpackage

/* rtl/core/canfrx_ram.sv */
// ----------------------------------------------------------------------------
// canfrx_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module canfrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/can_std_id_filter_rx_fifo.sv */
// ----------------------------------------------------------------------------
// can_std_id_filter_rx_fifo
// CAN receive path: ordered id/mask acceptance filter list and receive FIFO.
// ----------------------------------------------------------------------------
// Sequence: pop, add, clear and frames rejected before filtering go through
// S_UPDATE, S_HEAD_RD and S_HEAD; a frame that reaches the filters first walks
// the filter RAM in S_SCAN, one read per cycle, until a hit or the list end.
// The result register loads from S_HEAD once the output is free.
// One word is in work at a time; the next is taken once the result is queued.
// Reset (rst, synchronous): filter list and FIFO empty, both config bits 1.
module can_std_id_filter_rx_fifo #(
  parameter int FILTERS  = canfrx_pkg::FILTERS_DEF,
  parameter int RX_DEPTH = canfrx_pkg::RX_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [canfrx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                                cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [canfrx_pkg::ID_W-1:0]         frame_id,
  input  logic                                frame_extended,
  input  logic                                frame_remote,
  input  logic [canfrx_pkg::LEN_W-1:0]        frame_length,
  input  logic [canfrx_pkg::DATA_W-1:0]       frame_payload,
  input  logic [canfrx_pkg::ID_W-1:0]         filter_id,
  input  logic [canfrx_pkg::ID_W-1:0]         filter_mask,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic                                message_lost,
  output logic [canfrx_pkg::CNT_OUT_W-1:0]    fill_level,
  output logic                                fifo_full,
  output logic [canfrx_pkg::ID_W-1:0]         head_id,
  output logic [canfrx_pkg::LEN_W-1:0]        head_length,
  output logic [canfrx_pkg::DATA_W-1:0]       head_payload,
  output logic [canfrx_pkg::CNT_OUT_W-1:0]    filters_in_use
);
  import canfrx_pkg::*;

  `include "can_std_id_filter_rx_fifo_defines.svh"

  localparam int FAW     = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int FCNT_W  = $clog2(FILTERS + 1);
  localparam int RAW     = $clog2(RX_DEPTH);
  localparam int RCNT_W  = $clog2(RX_DEPTH + 1);
  localparam int SUM_W   = RCNT_W + 1;
  localparam int FILT_W  = 2 * ID_W;
  localparam int FRM_W   = ID_W + LEN_W + DATA_W;

  localparam logic [FCNT_W-1:0] FILTERS_C  = FCNT_W'(FILTERS);
  localparam logic [RCNT_W-1:0] RX_DEPTH_C = RCNT_W'(RX_DEPTH);
  localparam logic [SUM_W-1:0]  RX_DEPTH_S = SUM_W'(RX_DEPTH);
  localparam logic [RAW-1:0]    RI_LAST    = RAW'(RX_DEPTH - 1);

  // control state
  state_t              state, state_next;
  logic [FCNT_W-1:0]   filter_count, filter_count_next;
  logic [RCNT_W-1:0]   stored_count, stored_count_next;
  logic [RAW-1:0]      read_index, read_index_next;
  logic [FCNT_W-1:0]   scan_idx;
  logic                pend_valid;
  logic                match_hit;
  logic                acc_q, lost_q, acc_next, lost_next;
  logic                overwrite_when_full;
  logic                reject_remote_frames;

  // captured word
  opcode_t             op_q;
  logic [ID_W-1:0]     fid_q;
  logic [LEN_W-1:0]    flen_q;
  logic [DATA_W-1:0]   fdata_q;
  logic [ID_W-1:0]     filt_id_q;
  logic [ID_W-1:0]     filt_mask_q;

  // memory ports
  logic                filt_we, filt_re;
  logic [FAW-1:0]      filt_waddr, filt_raddr;
  logic [FILT_W-1:0]   filt_wdata, filt_rdata;
  logic                frm_we, frm_re;
  logic [RAW-1:0]      frm_waddr, frm_raddr;
  logic [FRM_W-1:0]    frm_wdata, frm_rdata;

  // helpers
  logic                accept_in;
  logic                out_free;
  logic                issue_ok;
  logic                hit;
  logic [ID_W-1:0]     cmp_mask;
  logic [SUM_W-1:0]    slot_sum;
  logic [SUM_W-1:0]    slot_wrap;
  logic [RAW-1:0]      slot;
  logic [RAW-1:0]      ri_inc;
  logic [31:0]         fill_wide;
  logic [31:0]         fcnt_wide;
  logic                drop_seen;

  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // filter compare on the word read last cycle: {mask, id}
  assign cmp_mask = filt_rdata[FILT_W-1:ID_W];
  assign hit      = pend_valid &&
                    ((fid_q & cmp_mask) == (filt_rdata[ID_W-1:0] & cmp_mask));
  assign issue_ok = (scan_idx < filter_count);

  // FIFO slot arithmetic
  assign slot_sum  = SUM_W'(read_index) + SUM_W'(stored_count);
  assign slot_wrap = (slot_sum >= RX_DEPTH_S) ? (slot_sum - RX_DEPTH_S) : slot_sum;
  assign slot      = slot_wrap[RAW-1:0];
  assign ri_inc    = (read_index == RI_LAST) ? '0 : read_index + 1'b1;

  // filter list memory
  canfrx_ram #(.WIDTH(FILT_W), .DEPTH(FILTERS)) u_filt_ram (
    .clk   (clk),
    .we    (filt_we),
    .waddr (filt_waddr),
    .wdata (filt_wdata),
    .re    (filt_re),
    .raddr (filt_raddr),
    .rdata (filt_rdata)
  );

  // frame store memory: {id, length, payload}
  canfrx_ram #(.WIDTH(FRM_W), .DEPTH(RX_DEPTH)) u_frm_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          if ((opcode == OP_FRAME) && !frame_extended &&
              !(frame_remote && reject_remote_frames)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_SCAN: begin
        if (hit || !issue_ok) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE:  state_next = S_HEAD_RD;
      S_HEAD_RD: state_next = S_HEAD;
      S_HEAD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // memory accesses and state updates per state
  always_comb begin
    filt_re           = 1'b0;
    filt_raddr        = scan_idx[FAW-1:0];
    filt_we           = 1'b0;
    filt_waddr        = filter_count[FAW-1:0];
    filt_wdata        = {filt_mask_q, filt_id_q};
    frm_we            = 1'b0;
    frm_waddr         = slot;
    frm_wdata         = {fid_q, flen_q, fdata_q};
    frm_re            = 1'b0;
    frm_raddr         = read_index;
    filter_count_next = filter_count;
    stored_count_next = stored_count;
    read_index_next   = read_index;
    acc_next          = acc_q;
    lost_next         = lost_q;
    case (state)
      S_IDLE: begin
        // new word: clear the result flags
        if (accept_in) begin
          acc_next  = 1'b0;
          lost_next = 1'b0;
        end
      end
      S_SCAN: begin
        filt_re = issue_ok && !hit;
      end
      S_UPDATE: begin
        case (op_q)
          OP_FRAME: begin
            if (match_hit) begin
              if (stored_count < RX_DEPTH_C) begin
                frm_we            = 1'b1;
                stored_count_next = stored_count + 1'b1;
                acc_next          = 1'b1;
              end else if (overwrite_when_full) begin
                // full: replace the oldest entry
                frm_we          = 1'b1;
                frm_waddr       = read_index;
                read_index_next = ri_inc;
                acc_next        = 1'b1;
                lost_next       = 1'b1;
              end else begin
                lost_next = 1'b1;
              end
            end
          end
          OP_POP: begin
            if (stored_count != '0) begin
              read_index_next   = ri_inc;
              stored_count_next = stored_count - 1'b1;
            end
          end
          OP_ADD: begin
            if (filter_count < FILTERS_C) begin
              filt_we           = 1'b1;
              filter_count_next = filter_count + 1'b1;
            end
          end
          OP_CLEAR: begin
            filter_count_next = '0;
          end
          default: ;
        endcase
      end
      S_HEAD_RD: begin
        frm_re = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      filter_count <= '0;
      stored_count <= '0;
      read_index   <= '0;
      scan_idx     <= '0;
      pend_valid   <= 1'b0;
      match_hit    <= 1'b0;
      acc_q        <= 1'b0;
      lost_q       <= 1'b0;
    end else begin
      state        <= state_next;
      filter_count <= filter_count_next;
      stored_count <= stored_count_next;
      read_index   <= read_index_next;
      acc_q        <= acc_next;
      lost_q       <= lost_next;
      if (accept_in) begin
        scan_idx   <= '0;
        pend_valid <= 1'b0;
        match_hit  <= 1'b0;
      end else if (state == S_SCAN) begin
        pend_valid <= filt_re;
        if (filt_re) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (hit) begin
          match_hit <= 1'b1;
        end
      end
    end
  end

  // captured word fields
  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_q        <= opcode_t'(opcode);
      fid_q       <= frame_id;
      flen_q      <= frame_length;
      fdata_q     <= frame_payload;
      filt_id_q   <= filter_id;
      filt_mask_q <= filter_mask;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overwrite_when_full  <= 1'b1;
      reject_remote_frames <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OVERWRITE:     overwrite_when_full  <= cfg_data;
        REG_REJECT_REMOTE: reject_remote_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  assign fill_wide = 32'(stored_count);
  assign fcnt_wide = 32'(filter_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_HEAD) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_HEAD) && out_free) begin
      accepted       <= acc_q;
      message_lost   <= lost_q;
      fill_level     <= fill_wide[CNT_OUT_W-1:0];
      fifo_full      <= (stored_count == RX_DEPTH_C);
      filters_in_use <= fcnt_wide[CNT_OUT_W-1:0];
      if (stored_count != '0) begin
        head_id      <= frm_rdata[FRM_W-1 -: ID_W];
        head_length  <= frm_rdata[DATA_W +: LEN_W];
        head_payload <= frm_rdata[DATA_W-1:0];
      end else begin
        head_id      <= '0;
        head_length  <= '0;
        head_payload <= '0;
      end
    end
  end

  // checks
  assign drop_seen = out_valid && message_lost && !accepted;

  `CANFRX_ASSERT_ALWAYS(a_fifo_bound, (stored_count <= RX_DEPTH_C), "FIFO count beyond depth")
  `CANFRX_ASSERT_ALWAYS(a_filt_bound, (filter_count <= FILTERS_C), "filter count beyond list")
  `CANFRX_ASSERT_ALWAYS(a_ri_bound, (read_index <= RI_LAST), "read index out of range")
  `CANFRX_ASSERT_NEXT(a_busy_after_accept, accept_in, (state != S_IDLE), "word accepted but idle")
  `CANFRX_ASSERT_SAME(a_drop_when_full, drop_seen, fifo_full, "frame dropped without full FIFO")

endmodule
